FILE: rtl/timed_event_queue_with_flush_unit_defines.svh
// ---------------------------------------------------------------------------
// Timed event queue assertion macros
// Shared concurrent assertion helpers for the queue checker.
// ---------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_WITH_FLUSH_UNIT_DEFINES_SVH
`define TIMED_EVENT_QUEUE_WITH_FLUSH_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define TEQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("teq: implication failed");

// next-cycle implication, masked during reset
`define TEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("teq: next-cycle check failed");

`endif

FILE: rtl/teq_pkg.sv
// ---------------------------------------------------------------------------
// Timed event queue package
// Command codes, field widths and result field positions.
// ---------------------------------------------------------------------------
`default_nettype none

package teq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int TYPE_COUNT_DEF  = 24;
	localparam int DELAY_BITS_DEF  = 16;

	localparam int CMD_W      = 2;
	localparam int TYPE_W     = 5;
	localparam int PARAM_W    = 8;
	localparam int IN_DELAY_W = 16;
	localparam int COUNT_W    = 7;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 24;

	// result field positions in m_tdata
	localparam int OUT_FIRED_BIT = 0;
	localparam int OUT_TYPE_LSB  = 1;
	localparam int OUT_PARAM_LSB = 6;
	localparam int OUT_COUNT_LSB = 14;
	localparam int OUT_OVF_BIT   = 21;

	localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/timed_event_queue_with_flush_unit.sv
// ---------------------------------------------------------------------------
// Timed event queue with flush
// FIFO of timed events held in a single-port-read synchronous store, with a
// head timer, one release per tick and an in-place flush of interactive
// entries.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata (lsb first)                         | tuser
//  ---------+-----+-------------------------------------------+---------
//  s_*      | in  | event_type, event_param, is_interactive,  | command
//           |     | delay_ticks                               |
//  m_*      | out | fired, fired_type, fired_param,           | -
//           |     | queue_count, overflow                     |
//
//  Enqueue, unused command, and tick or flush on an empty queue complete
//  directly from idle. A tick on a non-empty queue reads the head, then
//  compares and releases. A flush streams the store through its one read
//  port, one entry a cycle, and compacts the kept entries behind the read
//  pointer.
//  Reset clears pointers, counters, timer and the output valid flag; the
//  store itself is not cleared.
//  While a result waits on m_tready, s_tready stays low; the next transfer
//  can be taken in the cycle the waiting result leaves.
//
`default_nettype none

module timed_event_queue_with_flush_unit #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
	parameter int TYPE_COUNT  = teq_pkg::TYPE_COUNT_DEF,
	parameter int DELAY_BITS  = teq_pkg::DELAY_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// event_type[4:0], event_param[12:5], is_interactive[13],
	// delay_ticks[29:14], zero fill [31:30]
	input  wire logic [teq_pkg::S_TDATA_W-1:0] s_tdata,
	// command[1:0]
	input  wire logic [teq_pkg::CMD_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// fired[0], fired_type[5:1], fired_param[13:6], queue_count[20:14],
	// overflow[21], zero fill [23:22]
	output logic [teq_pkg::M_TDATA_W-1:0]      m_tdata
);

	localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam int EntW = teq_pkg::TYPE_W + teq_pkg::PARAM_W + 1 + DELAY_BITS;

	// entry layout: {delay, interactive, param, type}
	localparam int EntParamLsb = teq_pkg::TYPE_W;
	localparam int EntInterBit = teq_pkg::TYPE_W + teq_pkg::PARAM_W;
	localparam int EntDelayLsb = EntInterBit + 1;

	localparam logic [IdxW-1:0]       LastIdx  = IdxW'(QUEUE_DEPTH - 1);
	localparam logic [CntW-1:0]       FullCnt  = CntW'(QUEUE_DEPTH);
	localparam logic [DELAY_BITS-1:0] DelayMax = '1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_TICK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] p);
		return (p == LastIdx) ? '0 : p + 1'b1;
	endfunction

	// ---- state ------------------------------------------------------------
	logic [1:0]            state_q,   state_d;
	logic [IdxW-1:0]       head_q,    head_d;
	logic [IdxW-1:0]       tail_q,    tail_d;
	logic [CntW-1:0]       count_q,   count_d;
	logic [DELAY_BITS-1:0] elapsed_q, elapsed_d;

	// flush walk
	logic [IdxW-1:0] fl_rd_q,   fl_rd_d;
	logic [IdxW-1:0] fl_wr_q,   fl_wr_d;
	logic [CntW-1:0] fl_iss_q,  fl_iss_d;
	logic [CntW-1:0] fl_proc_q, fl_proc_d;
	logic [CntW-1:0] fl_kept_q, fl_kept_d;
	logic            fl_gone_q, fl_gone_d;

	// output register
	logic                          m_tvalid_q;
	logic [teq_pkg::M_TDATA_W-1:0] m_tdata_q;

	// entry store
	logic [EntW-1:0] mem_q [QUEUE_DEPTH];
	logic [EntW-1:0] rd_data_s1;
	logic            mem_we, mem_re;
	logic [IdxW-1:0] mem_wa, mem_ra;
	logic [EntW-1:0] mem_wd;

	// ---- input unpack -----------------------------------------------------
	logic                            in_fire;
	logic [teq_pkg::TYPE_W-1:0]      in_type;
	logic [teq_pkg::PARAM_W-1:0]     in_param;
	logic                            in_inter;
	logic [teq_pkg::IN_DELAY_W-1:0]  in_delay;
	logic [DELAY_BITS-1:0]           in_delay_sat;
	logic [EntW-1:0]                 in_entry;

	assign in_fire  = s_tvalid && s_tready;
	assign in_type  = s_tdata[4:0];
	assign in_param = s_tdata[12:5];
	assign in_inter = s_tdata[13];
	assign in_delay = s_tdata[29:14];

	// delays beyond the timer width saturate
	assign in_delay_sat = (32'(in_delay) > 32'(DelayMax)) ? DelayMax
	                                                     : DELAY_BITS'(in_delay);
	assign in_entry     = {in_delay_sat, in_inter, in_param, in_type};

	// ---- read data fields -------------------------------------------------
	logic [teq_pkg::TYPE_W-1:0]  rd_type;
	logic [teq_pkg::PARAM_W-1:0] rd_param;
	logic                        rd_inter;
	logic [DELAY_BITS-1:0]       rd_delay;

	assign rd_type  = rd_data_s1[teq_pkg::TYPE_W-1:0];
	assign rd_param = rd_data_s1[EntParamLsb +: teq_pkg::PARAM_W];
	assign rd_inter = rd_data_s1[EntInterBit];
	assign rd_delay = rd_data_s1[EntDelayLsb +: DELAY_BITS];

	// ---- result fields ----------------------------------------------------
	logic                        out_load;
	logic                        res_fired;
	logic [teq_pkg::TYPE_W-1:0]  res_type;
	logic [teq_pkg::PARAM_W-1:0] res_param;
	logic                        res_ovf;

	// scratch for tick and flush
	logic [DELAY_BITS-1:0] el_inc;
	logic                  fl_keep;
	logic [IdxW-1:0]       fl_wr_nx;
	logic [CntW-1:0]       fl_kept_nx;
	logic                  fl_gone_nx;

	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		elapsed_d = elapsed_q;
		fl_rd_d   = fl_rd_q;
		fl_wr_d   = fl_wr_q;
		fl_iss_d  = fl_iss_q;
		fl_proc_d = fl_proc_q;
		fl_kept_d = fl_kept_q;
		fl_gone_d = fl_gone_q;
		mem_we    = 1'b0;
		mem_wa    = tail_q;
		mem_wd    = in_entry;
		mem_re    = 1'b0;
		mem_ra    = head_q;
		out_load  = 1'b0;
		res_fired = 1'b0;
		res_type  = '0;
		res_param = '0;
		res_ovf   = 1'b0;

		el_inc     = (elapsed_q == DelayMax) ? elapsed_q : elapsed_q + 1'b1;
		fl_keep    = !rd_inter;
		fl_wr_nx   = fl_keep ? next_idx(fl_wr_q) : fl_wr_q;
		fl_kept_nx = fl_keep ? fl_kept_q + 1'b1 : fl_kept_q;
		fl_gone_nx = fl_gone_q || (!fl_keep && (fl_proc_q == '0));

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (s_tuser)
						teq_pkg::CMD_ENQUEUE: begin
							out_load = 1'b1;
							if ((in_type == '0 && in_delay == '0)
							    || (9'(in_type) >= 9'(TYPE_COUNT))) begin
								// dropped silently
							end else if (count_q == FullCnt) begin
								res_ovf = 1'b1;
							end else begin
								mem_we  = 1'b1;
								tail_d  = next_idx(tail_q);
								count_d = count_q + 1'b1;
								if (count_q == '0)
									elapsed_d = '0;
							end
						end
						teq_pkg::CMD_TICK: begin
							if (count_q == '0) begin
								elapsed_d = '0;
								out_load  = 1'b1;
							end else begin
								mem_re  = 1'b1;
								state_d = ST_TICK;
							end
						end
						teq_pkg::CMD_FLUSH: begin
							if (count_q == '0) begin
								tail_d    = head_q;
								elapsed_d = '0;
								out_load  = 1'b1;
							end else begin
								mem_re    = 1'b1;
								fl_rd_d   = next_idx(head_q);
								fl_wr_d   = head_q;
								fl_iss_d  = CntW'(1);
								fl_proc_d = '0;
								fl_kept_d = '0;
								fl_gone_d = 1'b0;
								state_d   = ST_FLUSH;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			ST_TICK: begin
				out_load = 1'b1;
				state_d  = ST_IDLE;
				if (el_inc >= rd_delay) begin
					res_fired = 1'b1;
					res_type  = rd_type;
					res_param = rd_param;
					head_d    = next_idx(head_q);
					count_d   = count_q - 1'b1;
					elapsed_d = '0;
				end else begin
					elapsed_d = el_inc;
				end
			end
			ST_FLUSH: begin
				// write lags read, so a compacting write never hits an
				// entry still to be read
				if (fl_keep) begin
					mem_we = 1'b1;
					mem_wa = fl_wr_q;
					mem_wd = rd_data_s1;
				end
				fl_wr_d   = fl_wr_nx;
				fl_kept_d = fl_kept_nx;
				fl_gone_d = fl_gone_nx;
				if (fl_iss_q != count_q) begin
					mem_re   = 1'b1;
					mem_ra   = fl_rd_q;
					fl_rd_d  = next_idx(fl_rd_q);
					fl_iss_d = fl_iss_q + 1'b1;
				end
				if (fl_proc_q == count_q - 1'b1) begin
					count_d  = fl_kept_nx;
					tail_d   = fl_wr_nx;
					if (fl_gone_nx || fl_kept_nx == '0)
						elapsed_d = '0;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					fl_proc_d = fl_proc_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---- control registers ------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			elapsed_q  <= '0;
			fl_rd_q    <= '0;
			fl_wr_q    <= '0;
			fl_iss_q   <= '0;
			fl_proc_q  <= '0;
			fl_kept_q  <= '0;
			fl_gone_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			elapsed_q <= elapsed_d;
			fl_rd_q   <= fl_rd_d;
			fl_wr_q   <= fl_wr_d;
			fl_iss_q  <= fl_iss_d;
			fl_proc_q <= fl_proc_d;
			fl_kept_q <= fl_kept_d;
			fl_gone_q <= fl_gone_d;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load)
			m_tdata_q <= {2'b00, res_ovf, teq_pkg::COUNT_W'(count_d),
			              res_param, res_type, res_fired};
	end

	// ---- entry store: one write, one registered read per cycle ------------
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_wa] <= mem_wd;
		if (mem_re)
			rd_data_s1 <= mem_q[mem_ra];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

FILE: rtl/teq_checker.sv
// ---------------------------------------------------------------------------
// Timed event queue checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "timed_event_queue_with_flush_unit_defines.svh"

module teq_checker #(
	parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
	parameter int TYPE_COUNT  = teq_pkg::TYPE_COUNT_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [teq_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam logic [teq_pkg::COUNT_W-1:0] CountFull = teq_pkg::COUNT_W'(QUEUE_DEPTH);

	logic                          fired;
	logic                          ovf;
	logic [teq_pkg::TYPE_W-1:0]    ftype;
	logic [teq_pkg::PARAM_W-1:0]   fparam;
	logic [teq_pkg::COUNT_W-1:0]   qcount;

	assign fired  = m_tdata[teq_pkg::OUT_FIRED_BIT];
	assign ovf    = m_tdata[teq_pkg::OUT_OVF_BIT];
	assign ftype  = m_tdata[teq_pkg::OUT_TYPE_LSB +: teq_pkg::TYPE_W];
	assign fparam = m_tdata[teq_pkg::OUT_PARAM_LSB +: teq_pkg::PARAM_W];
	assign qcount = m_tdata[teq_pkg::OUT_COUNT_LSB +: teq_pkg::COUNT_W];

	// no release: type and parameter read as zero
	`TEQ_ASSERT_IMPLY(a_idle_fields_zero, clk, arst_n, m_tvalid && !fired, ftype == '0 && fparam == '0)

	// a refused enqueue only happens on a full queue and never releases
	`TEQ_ASSERT_IMPLY(a_ovf_full, clk, arst_n, m_tvalid && ovf, qcount == CountFull && !fired)

	// released types were range-checked on entry
	`TEQ_ASSERT_IMPLY(a_fired_type_ok, clk, arst_n, m_tvalid && fired, 9'(ftype) < 9'(TYPE_COUNT))

	// a stalled result holds
	`TEQ_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind timed_event_queue_with_flush_unit teq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH),
	.TYPE_COUNT  (TYPE_COUNT)
) u_teq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
